FILE: src/bwts_pkg.sv
// shared types and constants for the bone weight top-two selector
package bwts_pkg;

    localparam int BONE_W      = 8;
    localparam int BONE_OUT_W  = 9;
    localparam int WEIGHT_W    = 17;
    localparam int TOTAL_W     = WEIGHT_W + 1;
    localparam int QUEUE_DEPTH = 2;

    localparam logic [BONE_OUT_W-1:0] NO_BONE = '1;

    // selection result of one vertex, handed from front to back
    typedef struct packed {
        logic                has_best;
        logic                has_sec;
        logic [BONE_W-1:0]   best_bone;
        logic [BONE_W-1:0]   sec_bone;
        logic [WEIGHT_W-1:0] best_weight;
        logic [WEIGHT_W-1:0] sec_weight;
    } t_pair;

endpackage

FILE: src/bwts_front.sv
// front part: filters influences and keeps the two largest weights of a vertex
module bwts_front #(
    parameter int MAX_BONES = 256
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_in_valid,
    output logic                             o_in_stall,
    input  logic [bwts_pkg::BONE_W-1:0]      i_bone_index,
    input  logic [bwts_pkg::WEIGHT_W-1:0]    i_weight,
    input  logic                             i_last_bone,
    input  logic                             i_queue_full,
    output logic                             o_push,
    output bwts_pkg::t_pair                  o_pair
);
    import bwts_pkg::*;

    t_pair r_cur;
    t_pair n_sel;
    logic  w_take;
    logic  w_accept;

    assign o_in_stall = i_queue_full;
    assign w_accept   = i_in_valid && !i_queue_full;
    assign w_take     = (i_weight != '0) && ({24'd0, i_bone_index} < 32'(MAX_BONES));

    // equal weights leave the earlier influence in place
    always_comb begin
        n_sel = r_cur;
        if (w_take) begin
            if (!r_cur.has_best) begin
                n_sel.has_best    = 1'b1;
                n_sel.best_bone   = i_bone_index;
                n_sel.best_weight = i_weight;
            end else if (i_weight > r_cur.best_weight) begin
                n_sel.has_sec     = 1'b1;
                n_sel.sec_bone    = r_cur.best_bone;
                n_sel.sec_weight  = r_cur.best_weight;
                n_sel.best_bone   = i_bone_index;
                n_sel.best_weight = i_weight;
            end else if (!r_cur.has_sec || i_weight > r_cur.sec_weight) begin
                n_sel.has_sec    = 1'b1;
                n_sel.sec_bone   = i_bone_index;
                n_sel.sec_weight = i_weight;
            end
        end
    end

    assign o_push = w_accept && i_last_bone;
    assign o_pair = n_sel;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cur.has_best <= 1'b0;
            r_cur.has_sec  <= 1'b0;
        end else if (w_accept) begin
            if (i_last_bone) begin
                r_cur.has_best <= 1'b0;
                r_cur.has_sec  <= 1'b0;
            end else begin
                r_cur <= n_sel;
            end
        end
    end

endmodule

FILE: src/bwts_fifo.sv
// short queue of selected pairs between front and back
module bwts_fifo (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  bwts_pkg::t_pair i_data,
    input  logic            i_pop,
    output bwts_pkg::t_pair o_head,
    output logic            o_full,
    output logic            o_empty
);
    import bwts_pkg::*;

    localparam int QA = $clog2(QUEUE_DEPTH);

    t_pair         r_mem [QUEUE_DEPTH];
    logic [QA-1:0] r_wr;
    logic [QA-1:0] r_rd;
    logic [QA:0]   r_cnt;

    assign o_full  = (r_cnt == (QA+1)'(QUEUE_DEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_head  = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wr <= r_wr + 1'b1;
            end
            if (i_pop) begin
                r_rd <= r_rd + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (i_pop && !i_push) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

endmodule

FILE: src/bwts_back.sv
// back part: normalizes a pair by two bit-serial dividers and holds the result
module bwts_back #(
    parameter int WEIGHT_FRAC_BITS = 16
) (
    input  logic                                    i_clk,
    input  logic                                    i_rst_n,
    input  logic                                    i_empty,
    input  bwts_pkg::t_pair                         i_head,
    output logic                                    o_pop,
    output logic                                    o_out_valid,
    input  logic                                    i_out_stall,
    output logic signed [bwts_pkg::BONE_OUT_W-1:0]  o_primary_bone,
    output logic signed [bwts_pkg::BONE_OUT_W-1:0]  o_secondary_bone,
    output logic [bwts_pkg::WEIGHT_W-1:0]           o_primary_share,
    output logic [bwts_pkg::WEIGHT_W-1:0]           o_secondary_share
);
    import bwts_pkg::*;

    localparam int FRAC = WEIGHT_FRAC_BITS;
    localparam int CW   = $clog2(FRAC + 1);
    localparam logic [WEIGHT_W-1:0] LONE_SHARE =
        (FRAC < WEIGHT_W) ? WEIGHT_W'(1 << FRAC) : '0;

    typedef enum logic [1:0] {
        S_IDLE,
        S_DIV,
        S_OUT
    } t_state;

    t_state                r_state;
    logic [CW-1:0]         r_cnt;
    logic [TOTAL_W-1:0]    r_total;
    logic [TOTAL_W-1:0]    r_rem0;
    logic [TOTAL_W-1:0]    r_rem1;
    logic [FRAC-1:0]       r_q0;
    logic [FRAC-1:0]       r_q1;
    logic [BONE_OUT_W-1:0] r_pb;
    logic [BONE_OUT_W-1:0] r_sb;
    logic [WEIGHT_W-1:0]   r_ps;
    logic [WEIGHT_W-1:0]   r_ss;

    logic [TOTAL_W:0]   w_sh0;
    logic [TOTAL_W:0]   w_sh1;
    logic               w_ge0;
    logic               w_ge1;
    logic [TOTAL_W-1:0] n_rem0;
    logic [TOTAL_W-1:0] n_rem1;

    // one quotient bit per cycle; remainder stays below the total
    assign w_sh0  = {r_rem0, 1'b0};
    assign w_sh1  = {r_rem1, 1'b0};
    assign w_ge0  = (w_sh0 >= {1'b0, r_total});
    assign w_ge1  = (w_sh1 >= {1'b0, r_total});
    assign n_rem0 = w_ge0 ? TOTAL_W'(w_sh0 - {1'b0, r_total}) : TOTAL_W'(w_sh0);
    assign n_rem1 = w_ge1 ? TOTAL_W'(w_sh1 - {1'b0, r_total}) : TOTAL_W'(w_sh1);

    assign o_pop             = (r_state == S_IDLE) && !i_empty;
    assign o_out_valid       = (r_state == S_OUT);
    assign o_primary_bone    = r_pb;
    assign o_secondary_bone  = r_sb;
    assign o_primary_share   = r_ps;
    assign o_secondary_share = r_ss;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (!i_empty) begin
                        r_pb <= i_head.has_best ? {1'b0, i_head.best_bone} : NO_BONE;
                        r_sb <= i_head.has_sec ? {1'b0, i_head.sec_bone} : NO_BONE;
                        if (i_head.has_best && i_head.has_sec) begin
                            r_total <= {1'b0, i_head.best_weight} + {1'b0, i_head.sec_weight};
                            r_rem0  <= {1'b0, i_head.best_weight};
                            r_rem1  <= {1'b0, i_head.sec_weight};
                            r_cnt   <= CW'(FRAC);
                            r_state <= S_DIV;
                        end else begin
                            r_ps    <= i_head.has_best ? LONE_SHARE : '0;
                            r_ss    <= '0;
                            r_state <= S_OUT;
                        end
                    end
                end
                S_DIV: begin
                    if (r_cnt != '0) begin
                        r_rem0 <= n_rem0;
                        r_rem1 <= n_rem1;
                        r_q0   <= {r_q0[FRAC-2:0], w_ge0};
                        r_q1   <= {r_q1[FRAC-2:0], w_ge1};
                        r_cnt  <= r_cnt - 1'b1;
                    end else begin
                        r_ps    <= WEIGHT_W'(r_q0);
                        r_ss    <= WEIGHT_W'(r_q1);
                        r_state <= S_OUT;
                    end
                end
                S_OUT: begin
                    if (!i_out_stall) begin
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

endmodule

FILE: src/bone_weight_top_two_select.sv
// top level of the bone weight top-two selector
//
// input channel: one bone influence per transfer (bone index, q1.16 weight,
// last flag); influences of one vertex arrive in a row, the last one flagged.
// zero weights and bones at or above max_bones are skipped.
// output channel: one transfer per vertex with the primary and secondary bone
// (-1 when absent) and their shares, normalized by truncating division.
// the front takes one influence every cycle and stalls only when the two-entry
// pair queue is full. the back runs two bit-serial dividers side by side, one
// quotient bit a cycle, and takes the next pair from the queue only once the
// result before it has been taken. a pair passes through the idle, divide and
// output states in turn; a lone or empty vertex goes from idle straight to
// output.
// reset clears the selection, empties the queue and drops a pending result.
// while the receiver stalls, the result holds steady and the queue keeps
// filling until full, after which the input is stalled.
module bone_weight_top_two_select #(
    parameter int MAX_BONES        = 256,
    parameter int WEIGHT_FRAC_BITS = 16
) (
    input  logic                                    i_clk,
    input  logic                                    i_rst_n,
    input  logic                                    i_in_valid,
    output logic                                    o_in_stall,
    input  logic [bwts_pkg::BONE_W-1:0]             i_bone_index,
    input  logic [bwts_pkg::WEIGHT_W-1:0]           i_weight,
    input  logic                                    i_last_bone,
    output logic                                    o_out_valid,
    input  logic                                    i_out_stall,
    output logic signed [bwts_pkg::BONE_OUT_W-1:0]  o_primary_bone,
    output logic signed [bwts_pkg::BONE_OUT_W-1:0]  o_secondary_bone,
    output logic [bwts_pkg::WEIGHT_W-1:0]           o_primary_share,
    output logic [bwts_pkg::WEIGHT_W-1:0]           o_secondary_share
);
    import bwts_pkg::*;

    // front to queue
    logic  w_push;
    t_pair w_pair;
    logic  w_full;
    // queue to back
    logic  w_pop;
    logic  w_empty;
    t_pair w_head;

    bwts_front #(
        .MAX_BONES (MAX_BONES)
    ) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_stall   (o_in_stall),
        .i_bone_index (i_bone_index),
        .i_weight     (i_weight),
        .i_last_bone  (i_last_bone),
        .i_queue_full (w_full),
        .o_push       (w_push),
        .o_pair       (w_pair)
    );

    bwts_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_data  (w_pair),
        .i_pop   (w_pop),
        .o_head  (w_head),
        .o_full  (w_full),
        .o_empty (w_empty)
    );

    // division runs here, one quotient bit per cycle
    bwts_back #(
        .WEIGHT_FRAC_BITS (WEIGHT_FRAC_BITS)
    ) u_back (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_empty           (w_empty),
        .i_head            (w_head),
        .o_pop             (w_pop),
        .o_out_valid       (o_out_valid),
        .i_out_stall       (i_out_stall),
        .o_primary_bone    (o_primary_bone),
        .o_secondary_bone  (o_secondary_bone),
        .o_primary_share   (o_primary_share),
        .o_secondary_share (o_secondary_share)
    );

endmodule

FILE: src/bwts_checker.sv
// port-level checks for the bone weight top-two selector, bound to the top level
module bwts_checker (
    input logic                                    i_clk,
    input logic                                    i_rst_n,
    input logic                                    o_out_valid,
    input logic                                    i_out_stall,
    input logic signed [bwts_pkg::BONE_OUT_W-1:0]  o_primary_bone,
    input logic signed [bwts_pkg::BONE_OUT_W-1:0]  o_secondary_bone,
    input logic [bwts_pkg::WEIGHT_W-1:0]           o_primary_share,
    input logic [bwts_pkg::WEIGHT_W-1:0]           o_secondary_share
);
    import bwts_pkg::*;

    // a stalled result stays offered
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid)
        else $error("result dropped while stalled");

    // reset leaves no result pending
    a_reset_clear: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid after reset");

    // an empty vertex reports no bones and zero shares
    a_empty_vertex: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_primary_bone == -1 |->
            o_secondary_bone == -1 && o_primary_share == '0 && o_secondary_share == '0)
        else $error("empty vertex with bone or share");

    // a secondary never appears without a primary
    a_sec_needs_primary: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_secondary_bone != -1 |-> o_primary_bone != -1)
        else $error("secondary bone without primary");

endmodule

bind bone_weight_top_two_select bwts_checker u_bwts_checker (.*);

FILE: bench/tb_bone_weight_top_two_select.sv
// testbench for the bone weight top-two selector: random and directed vertices, scoreboard check
module tb_bone_weight_top_two_select;
    import bwts_pkg::*;

    localparam int FRAC_BITS   = 16;
    localparam int DRAIN_LIMIT = 20000;

    // one bone influence as it crosses the input channel
    typedef struct {
        logic [BONE_W-1:0]   bone;
        logic [WEIGHT_W-1:0] weight;
        logic                last;
    } influence_t;

    // one per-vertex result as it crosses the output channel
    typedef struct {
        logic signed [BONE_OUT_W-1:0] primary_bone;
        logic signed [BONE_OUT_W-1:0] secondary_bone;
        logic [WEIGHT_W-1:0]          primary_share;
        logic [WEIGHT_W-1:0]          secondary_share;
    } bone_pair_t;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_in_valid = 1'b0;
    logic [BONE_W-1:0] i_bone_index = '0;
    logic [WEIGHT_W-1:0] i_weight = '0;
    logic i_last_bone = 1'b0;
    logic i_out_stall = 1'b0;
    logic o_in_stall;
    logic o_out_valid;
    logic signed [BONE_OUT_W-1:0] o_primary_bone;
    logic signed [BONE_OUT_W-1:0] o_secondary_bone;
    logic [WEIGHT_W-1:0] o_primary_share;
    logic [WEIGHT_W-1:0] o_secondary_share;

    bone_weight_top_two_select dut (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_in_valid        (i_in_valid),
        .o_in_stall        (o_in_stall),
        .i_bone_index      (i_bone_index),
        .i_weight          (i_weight),
        .i_last_bone       (i_last_bone),
        .o_out_valid       (o_out_valid),
        .i_out_stall       (i_out_stall),
        .o_primary_bone    (o_primary_bone),
        .o_secondary_bone  (o_secondary_bone),
        .o_primary_share   (o_primary_share),
        .o_secondary_share (o_secondary_share)
    );

    // stimulus waiting to be driven, and vertex results still owed by the block
    influence_t influence_queue[$];
    bone_pair_t owed_pairs[$];

    // shadow of the selection state: leader and runner-up of the current vertex
    logic signed [BONE_OUT_W-1:0] lead_bone   = NO_BONE;
    logic signed [BONE_OUT_W-1:0] runner_bone = NO_BONE;
    logic [WEIGHT_W-1:0]          lead_w      = '0;
    logic [WEIGHT_W-1:0]          runner_w    = '0;

    int  mismatch_count = 0;
    int  sent_count = 0;
    int  taken_count = 0;
    int  vertex_count = 0;
    int  compared_count = 0;
    logic in_taken = 1'b0;

    // no idling on either side while this window of transfers goes through
    wire calm = (sent_count >= 250) && (sent_count < 400);

    initial begin
        forever #10 i_clk = ~i_clk;
    end

    // rank one influence against the shadow state; on the last one, queue the
    // normalized pair and clear the state for the next vertex
    task automatic rank_influence(input influence_t inf);
        bone_pair_t                   pair;
        logic [2*WEIGHT_W-1:0]        total;
        logic signed [BONE_OUT_W-1:0] bone9;
        bone9 = $signed({1'b0, inf.bone});
        // the 8-bit index is always below the 256-entry bone limit
        if (inf.weight != '0) begin
            if (lead_bone == NO_BONE) begin
                lead_bone = bone9;
                lead_w    = inf.weight;
            end else if (inf.weight > lead_w) begin
                // a new maximum demotes the current leader
                runner_bone = lead_bone;
                runner_w    = lead_w;
                lead_bone   = bone9;
                lead_w      = inf.weight;
            end else if (runner_bone == NO_BONE || inf.weight > runner_w) begin
                runner_bone = bone9;
                runner_w    = inf.weight;
            end
        end
        if (inf.last) begin
            pair.primary_bone    = lead_bone;
            pair.secondary_bone  = runner_bone;
            pair.primary_share   = '0;
            pair.secondary_share = '0;
            if (lead_bone != NO_BONE) begin
                if (runner_bone == NO_BONE) begin
                    pair.primary_share = WEIGHT_W'(1) << FRAC_BITS;
                end else begin
                    total = lead_w + runner_w;
                    pair.primary_share   = WEIGHT_W'(({lead_w, 16'b0}) / total);
                    pair.secondary_share = WEIGHT_W'(({runner_w, 16'b0}) / total);
                end
            end
            owed_pairs = {owed_pairs, pair};
            lead_bone   = NO_BONE;
            runner_bone = NO_BONE;
            lead_w      = '0;
            runner_w    = '0;
        end
    endtask

    task automatic check_field(input string what, input int want, input int got);
        if (want != got) begin
            mismatch_count++;
            if (mismatch_count <= 40) begin
                $display("%0t: %s mismatch, expected %0d, got %0d", $time, what, want, got);
            end
        end
    endtask

    // driver: a new influence goes out once the previous one is transferred
    always @(negedge i_clk) begin
        influence_t inf;
        if (i_rst_n) begin
            if (!i_in_valid || in_taken) begin
                if (influence_queue.size() > 0 && (calm || $urandom_range(99) >= 21)) begin
                    inf = influence_queue.pop_front();
                    i_bone_index <= inf.bone;
                    i_weight     <= inf.weight;
                    i_last_bone  <= inf.last;
                    i_in_valid   <= 1'b1;
                    sent_count++;
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
            i_out_stall <= !calm && ($urandom_range(99) < 21);
        end
    end

    // input side: each influence transfer updates the prediction
    always @(posedge i_clk) begin
        influence_t inf;
        in_taken <= i_in_valid && !o_in_stall;
        if (i_rst_n && i_in_valid && !o_in_stall) begin
            inf.bone   = i_bone_index;
            inf.weight = i_weight;
            inf.last   = i_last_bone;
            rank_influence(inf);
            taken_count++;
        end
    end

    // output side: each result transfer is compared with the oldest owed pair
    always @(posedge i_clk) begin
        bone_pair_t want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (owed_pairs.size() == 0) begin
                mismatch_count++;
                $display("%0t: unexpected result, expected none, got bones %0d/%0d",
                         $time, o_primary_bone, o_secondary_bone);
            end else begin
                want = owed_pairs.pop_front();
                check_field("primary_bone", want.primary_bone, o_primary_bone);
                check_field("secondary_bone", want.secondary_bone, o_secondary_bone);
                check_field("primary_share", want.primary_share, o_primary_share);
                check_field("secondary_share", want.secondary_share, o_secondary_share);
                compared_count++;
            end
        end
    end

    task automatic add_influence(input int bone, input int weight, input bit last);
        influence_t inf;
        inf.bone   = BONE_W'(bone);
        inf.weight = WEIGHT_W'(weight);
        inf.last   = last;
        influence_queue = {influence_queue, inf};
        if (last) vertex_count++;
    endtask

    // weight mix: zeros, exactly 1.0, any 17-bit value, repeats of the last weight, tiny weights, values up to 1.0
    function automatic int pick_weight(input int prev);
        int roll;
        roll = $urandom_range(99);
        if (roll < 10) return 0;
        if (roll < 20) return 1 << FRAC_BITS;
        if (roll < 30) return $urandom_range((1 << WEIGHT_W) - 1);
        if (roll < 40 && prev != 0) return prev;
        if (roll < 45) return $urandom_range(1, 15);
        return $urandom_range(1, 1 << FRAC_BITS);
    endfunction

    initial begin
        int len;
        int bone;
        int prev_w;
        int waited;

        // empty vertex: only a zero weight
        add_influence(0, 0, 1);
        // lone primaries at both ends of the bone range
        add_influence(0, 1, 1);
        add_influence(255, 65536, 1);
        // plain pair
        add_influence(3, 'h8000, 0);
        add_influence(7, 'h4000, 1);
        // rising weights: each new maximum demotes the leader, the small one
        // is dropped, and a zero-weight last still closes the vertex
        add_influence(10, 100, 0);
        add_influence(11, 200, 0);
        add_influence(12, 300, 0);
        add_influence(13, 50, 0);
        add_influence(14, 0, 1);
        // runner-up replaced by a weight between the two
        add_influence(20, 1000, 0);
        add_influence(21, 10, 0);
        add_influence(22, 500, 1);
        // equal weights keep the earlier influence ahead
        add_influence(1, 500, 0);
        add_influence(2, 500, 0);
        add_influence(3, 500, 1);
        // weights above 1.0, all bits set
        add_influence(254, 'h1FFFF, 0);
        add_influence(255, 'h1FFFF, 1);
        // bones out of ascending order, smallest nonzero weight
        add_influence(200, 1, 0);
        add_influence(10, 'h1FFFF, 1);
        // sequence of zeros only
        add_influence(5, 0, 0);
        add_influence(6, 0, 1);

        // random vertices, mostly short with ascending bones
        while (influence_queue.size() < 620) begin
            if ($urandom_range(99) < 70) len = $urandom_range(1, 4);
            else if ($urandom_range(99) < 85) len = $urandom_range(5, 8);
            else len = $urandom_range(9, 14);
            bone = $urandom_range(0, 200);
            prev_w = 0;
            for (int k = 0; k < len; k++) begin
                prev_w = pick_weight(prev_w);
                add_influence(bone, prev_w, k == len - 1);
                if ($urandom_range(99) < 5) bone = $urandom_range(255);
                else bone = (bone + $urandom_range(1, 8) > 255) ? 255 : bone + $urandom_range(1, 8);
            end
        end

        repeat (3) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // every influence transferred, then every owed pair returned
        while (influence_queue.size() > 0 || i_in_valid) @(posedge i_clk);
        waited = 0;
        while (owed_pairs.size() > 0 && waited < DRAIN_LIMIT) begin
            @(posedge i_clk);
            waited++;
        end
        repeat (40) @(posedge i_clk);
        if (owed_pairs.size() > 0) begin
            mismatch_count++;
            $display("%0t: %0d results never arrived, expected 0 left, got %0d",
                     $time, owed_pairs.size(), owed_pairs.size());
        end

        $display("tb: %0d influences in %0d vertices transferred, %0d results compared",
                 taken_count, vertex_count, compared_count);
        $display("tb: %0d mismatches seen", mismatch_count);
        if (mismatch_count == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

    // hard stop well beyond the slowest legal run
    initial begin
        #5000000;
        $display("tb: failure");
        $finish;
    end

endmodule

FILE: filelist.f
src/bwts_pkg.sv
src/bwts_front.sv
src/bwts_fifo.sv
src/bwts_back.sv
src/bone_weight_top_two_select.sv
src/bwts_checker.sv
bench/tb_bone_weight_top_two_select.sv
